FILE: src/hsld_pkg.sv
package hsld_pkg;

   localparam logic [7:0] HDR0 = 8'hCC;
   localparam logic [7:0] HDR1 = 8'h81;
   localparam logic [23:0] PREAMBLE_LEN = 24'd5;

   localparam logic [16:0] MIN_LEN_RESET = 17'd5;
   localparam logic [23:0] MAX_LEN_RESET = 24'd65536;

   localparam int CSR_DATA_W = 24;
   localparam int CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_BIG_ENDIAN = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MIN_LEN = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_LEN = 2'd2;

   localparam logic [1:0] ERR_NONE = 2'd0;
   localparam logic [1:0] ERR_SHORT = 2'd1;
   localparam logic [1:0] ERR_LONG = 2'd2;

   localparam int FIFO_DEPTH = 8;

   typedef enum logic [1:0] {
      CMD_ERR,
      CMD_PRE,
      CMD_BODY
   } cmd_kind_type;

   // data carries the body byte, or the first length byte for a preamble
   typedef struct packed {
      cmd_kind_type kind;
      logic [7:0] data;
      logic [7:0] len1;
      logic [7:0] len2;
      logic last;
      logic [1:0] err;
   } cmd_type;

   typedef struct packed {
      logic big_endian;
      logic [16:0] min_len;
      logic [23:0] max_len;
   } cfg_type;

endpackage

FILE: src/hsld_front.sv
module hsld_front (
   input logic clock,
   input logic reset,
   input hsld_pkg::cfg_type cfg,
   input logic acc,
   input logic [7:0] rx_byte,
   output logic push,
   output hsld_pkg::cmd_type cmd
);
   import hsld_pkg::*;

   localparam logic [2:0] PH_HUNT = 3'd0;
   localparam logic [2:0] PH_HDR = 3'd1;
   localparam logic [2:0] PH_LEN0 = 3'd2;
   localparam logic [2:0] PH_LEN1 = 3'd3;
   localparam logic [2:0] PH_LEN2 = 3'd4;
   localparam logic [2:0] PH_BODY = 3'd5;

   logic [2:0] phase_ff, phase_in;
   logic [7:0] len0_ff, len0_in;
   logic [7:0] len1_ff, len1_in;
   logic [23:0] remaining_ff, remaining_in;
   logic [23:0] len;
   logic too_short, too_long;

   always_comb begin
      len = cfg.big_endian ? {len0_ff, len1_ff, rx_byte} : {rx_byte, len1_ff, len0_ff};
      too_short = (len < {7'd0, cfg.min_len}) || (len < PREAMBLE_LEN);
      too_long = len > cfg.max_len;
   end

   always_comb begin
      phase_in = phase_ff;
      len0_in = len0_ff;
      len1_in = len1_ff;
      remaining_in = remaining_ff;
      push = 1'b0;
      cmd.kind = CMD_BODY;
      cmd.data = rx_byte;
      cmd.len1 = len1_ff;
      cmd.len2 = rx_byte;
      cmd.last = 1'b0;
      cmd.err = ERR_NONE;
      if (acc) begin
         case (phase_ff)
            PH_HDR: begin
               if (rx_byte == HDR1) begin
                  phase_in = PH_LEN0;
               end else if (rx_byte == HDR0) begin
                  phase_in = PH_HDR;
               end else begin
                  phase_in = PH_HUNT;
               end
            end
            PH_LEN0: begin
               len0_in = rx_byte;
               phase_in = PH_LEN1;
            end
            PH_LEN1: begin
               len1_in = rx_byte;
               phase_in = PH_LEN2;
            end
            PH_LEN2: begin
               push = 1'b1;
               phase_in = PH_HUNT;
               if (too_short) begin
                  cmd.kind = CMD_ERR;
                  cmd.err = ERR_SHORT;
               end else if (too_long) begin
                  cmd.kind = CMD_ERR;
                  cmd.err = ERR_LONG;
               end else begin
                  cmd.kind = CMD_PRE;
                  cmd.data = len0_ff;
                  remaining_in = len - PREAMBLE_LEN;
                  cmd.last = (len == PREAMBLE_LEN);
                  if (len != PREAMBLE_LEN) begin
                     phase_in = PH_BODY;
                  end
               end
            end
            PH_BODY: begin
               push = 1'b1;
               remaining_in = remaining_ff - 24'd1;
               cmd.last = (remaining_ff == 24'd1);
               if (remaining_ff == 24'd1) begin
                  phase_in = PH_HUNT;
               end
            end
            default: begin
               phase_in = (rx_byte == HDR0) ? PH_HDR : PH_HUNT;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT;
         remaining_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         remaining_ff <= remaining_in;
      end
      len0_ff <= len0_in;
      len1_ff <= len1_in;
   end

endmodule

FILE: src/hsld_fifo.sv
module hsld_fifo (
   input logic clock,
   input logic reset,
   input logic push,
   input hsld_pkg::cmd_type push_cmd,
   input logic pop,
   output logic full,
   output logic head_valid,
   output hsld_pkg::cmd_type head_cmd
);
   import hsld_pkg::*;

   localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
   localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(FIFO_DEPTH - 1);

   cmd_type mem_ff [FIFO_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic do_push, do_pop;

   always_comb begin
      full = (count_ff == CNT_W'(FIFO_DEPTH));
      head_valid = (count_ff != '0);
      head_cmd = mem_ff[rd_ptr_ff];
      do_push = push && !full;
      do_pop = pop && head_valid;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

FILE: src/hsld_back.sv
module hsld_back (
   input logic clock,
   input logic reset,
   input logic head_valid,
   input hsld_pkg::cmd_type head_cmd,
   output logic pop,
   output logic rsp_valid,
   input logic rsp_ready,
   output logic [7:0] rsp_frame_byte,
   output logic rsp_first_flag,
   output logic rsp_last_flag,
   output logic [1:0] rsp_error_code
);
   import hsld_pkg::*;

   // preamble walks CC, 81, three length bytes
   localparam logic [2:0] PRE_LAST = 3'd4;

   logic [2:0] sub_ff, sub_in;
   logic valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;
   logic first_ff, first_in;
   logic last_ff, last_in;
   logic [1:0] err_ff, err_in;
   logic load;

   always_comb begin
      load = !valid_ff || rsp_ready;
      sub_in = sub_ff;
      valid_in = valid_ff && !rsp_ready;
      byte_in = byte_ff;
      first_in = first_ff;
      last_in = last_ff;
      err_in = err_ff;
      pop = 1'b0;
      if (load && head_valid) begin
         valid_in = 1'b1;
         first_in = 1'b0;
         last_in = 1'b0;
         err_in = ERR_NONE;
         byte_in = head_cmd.data;
         pop = 1'b1;
         case (head_cmd.kind)
            CMD_PRE: begin
               case (sub_ff)
                  3'd0: begin
                     byte_in = HDR0;
                     first_in = 1'b1;
                  end
                  3'd1: byte_in = HDR1;
                  3'd2: byte_in = head_cmd.data;
                  3'd3: byte_in = head_cmd.len1;
                  default: begin
                     byte_in = head_cmd.len2;
                     last_in = head_cmd.last;
                  end
               endcase
               if (sub_ff == PRE_LAST) begin
                  sub_in = '0;
               end else begin
                  sub_in = sub_ff + 3'd1;
                  pop = 1'b0;
               end
            end
            CMD_BODY: begin
               last_in = head_cmd.last;
            end
            default: begin
               byte_in = '0;
               err_in = head_cmd.err;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sub_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         sub_ff <= sub_in;
         valid_ff <= valid_in;
      end
      byte_ff <= byte_in;
      first_ff <= first_in;
      last_ff <= last_in;
      err_ff <= err_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_frame_byte = byte_ff;
   assign rsp_first_flag = first_ff;
   assign rsp_last_flag = last_ff;
   assign rsp_error_code = err_ff;

endmodule

FILE: src/header_sync_length_deframer_top.sv
// Byte-stream deframer. Each request on req_ carries one received byte. The
// block hunts for the header CC 81, reads three length bytes and checks the
// total length against csr min/max. A bad length gives one rsp_ item with
// rsp_error_code set; a good one gives the five preamble bytes, then one item
// per body byte, first flag on the CC, last flag on the final byte.
// The csr_ port writes length byte order (0), min (1) and max (2) lengths;
// write only while idle.
// Each response passes the command queue and then the output register.
// Throughput: one byte per cycle while rsp_ready is high; the five preamble
// bytes come from one queue entry, and the eight-entry queue between parser
// and emitter absorbs a backlog of at most five commands, so a back-to-back
// stream with rsp_ready held high never sees req_ready drop.
// Reset (synchronous) returns to hunting, empties the queue and restores the
// default registers. When rsp_ready is low the output holds, the queue fills
// and req_ready drops; nothing is lost.
module header_sync_length_deframer_top (
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_ready,
   input logic [7:0] req_rx_byte,
   output logic rsp_valid,
   input logic rsp_ready,
   output logic [7:0] rsp_frame_byte,
   output logic rsp_first_flag,
   output logic rsp_last_flag,
   output logic [1:0] rsp_error_code,
   input logic csr_we,
   input logic [hsld_pkg::CSR_INDEX_W-1:0] csr_index,
   input logic [hsld_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import hsld_pkg::*;

   cfg_type cfg_ff, cfg_in;
   logic full, acc, push, pop, head_valid;
   cmd_type push_cmd, head_cmd;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_BIG_ENDIAN: cfg_in.big_endian = csr_wdata[0];
            CSR_MIN_LEN: cfg_in.min_len = csr_wdata[16:0];
            CSR_MAX_LEN: cfg_in.max_len = csr_wdata[23:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.big_endian <= 1'b0;
         cfg_ff.min_len <= MIN_LEN_RESET;
         cfg_ff.max_len <= MAX_LEN_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign req_ready = !full;
   assign acc = req_valid && req_ready;

   hsld_front u_front (
      .clock(clock),
      .reset(reset),
      .cfg(cfg_ff),
      .acc(acc),
      .rx_byte(req_rx_byte),
      .push(push),
      .cmd(push_cmd)
   );

   hsld_fifo u_fifo (
      .clock(clock),
      .reset(reset),
      .push(push),
      .push_cmd(push_cmd),
      .pop(pop),
      .full(full),
      .head_valid(head_valid),
      .head_cmd(head_cmd)
   );

   hsld_back u_back (
      .clock(clock),
      .reset(reset),
      .head_valid(head_valid),
      .head_cmd(head_cmd),
      .pop(pop),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_frame_byte(rsp_frame_byte),
      .rsp_first_flag(rsp_first_flag),
      .rsp_last_flag(rsp_last_flag),
      .rsp_error_code(rsp_error_code)
   );

endmodule

FILE: verif/header_sync_length_deframer_top_test.sv
module header_sync_length_deframer_top_test;
   import hsld_pkg::*;

   localparam int CYCLE_LIMIT = 500000;
   localparam int SETTLE_CYCLES = 8;

   typedef enum logic [2:0] {
      SEEK_HDR0,
      SEEK_HDR1,
      LEN_B0,
      LEN_B1,
      LEN_B2,
      IN_BODY
   } sync_phase_type;

   typedef struct packed {
      logic [7:0] frame_byte;
      logic first_flag;
      logic last_flag;
      logic [1:0] error_code;
   } frame_item_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [7:0] req_rx_byte = 8'h00;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [7:0] rsp_frame_byte;
   logic rsp_first_flag;
   logic rsp_last_flag;
   logic [1:0] rsp_error_code;
   logic csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_BIG_ENDIAN;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // predictor state
   logic cfg_big_endian = 1'b0;
   logic [16:0] cfg_min_len = MIN_LEN_RESET;
   logic [23:0] cfg_max_len = MAX_LEN_RESET;
   sync_phase_type phase = SEEK_HDR0;
   logic [7:0] len_hold [3];
   logic [23:0] body_left = '0;

   frame_item_type frame_items_due [$];
   int mismatches = 0;
   int cycles = 0;
   int counted_bytes = 0;
   int req_gap_pct = 0;
   int rsp_stall_pct = 0;

   header_sync_length_deframer_top uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_rx_byte(req_rx_byte),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_frame_byte(rsp_frame_byte),
      .rsp_first_flag(rsp_first_flag),
      .rsp_last_flag(rsp_last_flag),
      .rsp_error_code(rsp_error_code),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   function void push_item(input logic [7:0] b, input logic first, input logic last,
                           input logic [1:0] err);
      frame_item_type item;
      item.frame_byte = b;
      item.first_flag = first;
      item.last_flag = last;
      item.error_code = err;
      frame_items_due.push_back(item);
   endfunction

   function void deframe_byte(input logic [7:0] b);
      logic [23:0] total;
      case (phase)
         SEEK_HDR1: begin
            if (b == HDR1) begin
               phase = LEN_B0;
            end else if (b == HDR0) begin
               phase = SEEK_HDR1;
            end else begin
               phase = SEEK_HDR0;
            end
         end
         LEN_B0: begin
            len_hold[0] = b;
            phase = LEN_B1;
         end
         LEN_B1: begin
            len_hold[1] = b;
            phase = LEN_B2;
         end
         LEN_B2: begin
            len_hold[2] = b;
            if (cfg_big_endian) begin
               total = {len_hold[0], len_hold[1], len_hold[2]};
            end else begin
               total = {len_hold[2], len_hold[1], len_hold[0]};
            end
            phase = SEEK_HDR0;
            if (total < {7'd0, cfg_min_len} || total < PREAMBLE_LEN) begin
               push_item(8'h00, 1'b0, 1'b0, ERR_SHORT);
            end else if (total > cfg_max_len) begin
               push_item(8'h00, 1'b0, 1'b0, ERR_LONG);
            end else begin
               body_left = total - PREAMBLE_LEN;
               push_item(HDR0, 1'b1, 1'b0, ERR_NONE);
               push_item(HDR1, 1'b0, 1'b0, ERR_NONE);
               push_item(len_hold[0], 1'b0, 1'b0, ERR_NONE);
               push_item(len_hold[1], 1'b0, 1'b0, ERR_NONE);
               push_item(len_hold[2], 1'b0, body_left == 24'd0, ERR_NONE);
               if (body_left != 24'd0) begin
                  phase = IN_BODY;
               end
            end
         end
         IN_BODY: begin
            body_left = body_left - 24'd1;
            push_item(b, 1'b0, body_left == 24'd0, ERR_NONE);
            if (body_left == 24'd0) begin
               phase = SEEK_HDR0;
            end
         end
         default: begin
            phase = (b == HDR0) ? SEEK_HDR1 : SEEK_HDR0;
         end
      endcase
   endfunction

   always @(posedge clock) begin : check_responses
      frame_item_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (frame_items_due.size() == 0) begin
            $error("response with no request pending: byte %0h err %0d",
                   rsp_frame_byte, rsp_error_code);
            mismatches++;
         end else begin
            want = frame_items_due.pop_front();
            if (rsp_frame_byte !== want.frame_byte) begin
               $error("frame_byte: expected %0h, got %0h", want.frame_byte, rsp_frame_byte);
               mismatches++;
            end
            if (rsp_first_flag !== want.first_flag) begin
               $error("first_flag: expected %0b, got %0b", want.first_flag, rsp_first_flag);
               mismatches++;
            end
            if (rsp_last_flag !== want.last_flag) begin
               $error("last_flag: expected %0b, got %0b", want.last_flag, rsp_last_flag);
               mismatches++;
            end
            if (rsp_error_code !== want.error_code) begin
               $error("error_code: expected %0d, got %0d", want.error_code, rsp_error_code);
               mismatches++;
            end
         end
      end
   end

   task automatic send_byte(input logic [7:0] b);
      while ($urandom_range(99) < req_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (!req_ready);
      if (phase != SEEK_HDR0 || b == HDR0) begin
         counted_bytes++;
      end
      deframe_byte(b);
   endtask

   task automatic send_length(input logic [23:0] total);
      if (cfg_big_endian) begin
         send_byte(total[23:16]);
         send_byte(total[15:8]);
         send_byte(total[7:0]);
      end else begin
         send_byte(total[7:0]);
         send_byte(total[15:8]);
         send_byte(total[23:16]);
      end
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (frame_items_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // write all three registers back to back
   task automatic configure(input logic big, input logic [16:0] min_len,
                            input logic [23:0] max_len);
      cfg_big_endian = big;
      cfg_min_len = min_len;
      cfg_max_len = max_len;
      csr_we <= 1'b1;
      csr_index <= CSR_BIG_ENDIAN;
      csr_wdata <= {23'd0, big};
      @(posedge clock);
      csr_index <= CSR_MIN_LEN;
      csr_wdata <= {7'd0, min_len};
      @(posedge clock);
      csr_index <= CSR_MAX_LEN;
      csr_wdata <= max_len;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // bring the stream back to hunting so the registers can change
   task automatic finish_frame();
      while (phase != SEEK_HDR0) send_byte(8'h00);
   endtask

   task automatic test_header_hunt();
      send_byte(HDR0);
      send_byte(8'h42);
      send_byte(HDR0);
      send_byte(HDR0);
      send_byte(HDR1);
      send_length(24'd5);
      wait_idle();
   endtask

   task automatic test_body_bytes();
      send_byte(HDR0);
      send_byte(HDR1);
      send_length(24'd8);
      send_byte(HDR0);
      send_byte(8'h00);
      send_byte(8'hFF);
      wait_idle();
   endtask

   task automatic test_length_bounds();
      configure(1'b1, 17'd0, 24'hFFFFFF);
      send_byte(HDR0);
      send_byte(HDR1);
      send_length(24'd3);
      wait_idle();
      // minimum above maximum reports too short
      configure(1'b1, 17'h1FFFF, 24'd5);
      send_byte(HDR0);
      send_byte(HDR1);
      send_length(24'd5);
      wait_idle();
      configure(1'b0, 17'd5, 24'd5);
      send_byte(HDR0);
      send_byte(HDR1);
      send_length(24'd6);
      send_byte(HDR0);
      send_byte(HDR1);
      send_length(24'd5);
      wait_idle();
   endtask

   task automatic send_random_frame();
      int unsigned kind;
      int unsigned lo;
      int unsigned hi;
      int unsigned total;
      int unsigned n;
      kind = $urandom_range(99);
      lo = (cfg_min_len > 5) ? cfg_min_len : 5;
      hi = (lo + 40 > cfg_max_len) ? cfg_max_len : lo + 40;
      if (kind < 8) begin
         n = $urandom_range(4, 1);
         repeat (n) send_byte($urandom_range(3) == 0 ? HDR0 : 8'($urandom));
      end else if (kind < 14) begin
         send_byte(HDR0);
         send_byte($urandom_range(1) ? HDR0 : 8'($urandom_range(255, 0)));
      end else begin
         if ($urandom_range(4) == 0) begin
            send_byte(HDR0);
         end
         send_byte(HDR0);
         send_byte(HDR1);
         if (kind < 24) begin
            total = $urandom_range(lo - 1, 0);
         end else if (kind < 30 && cfg_max_len < 24'hFFFFFF) begin
            total = cfg_max_len + 1 + $urandom_range(200);
            if (total > 24'hFFFFFF) begin
               total = 24'hFFFFFF;
            end
         end else if (kind < 34 && cfg_max_len < 24'hFFFFFF) begin
            total = $urandom_range(24'hFFFFFF, cfg_max_len + 1);
         end else if (lo > hi) begin
            total = lo;
         end else begin
            total = $urandom_range(hi, lo);
         end
         send_length(24'(total));
         if (total >= lo && total <= cfg_max_len) begin
            repeat (total - 5) send_byte($urandom_range(7) == 0 ? HDR0 : 8'($urandom));
         end
      end
   endtask

   task automatic test_random_traffic(input int gap_pct, input int stall_pct, input logic big,
                                      input logic [16:0] min_len, input logic [23:0] max_len,
                                      input int quota);
      int target;
      req_gap_pct = gap_pct;
      rsp_stall_pct = stall_pct;
      configure(big, min_len, max_len);
      target = counted_bytes + quota;
      while (counted_bytes < target) send_random_frame();
      finish_frame();
      wait_idle();
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_header_hunt();
      test_body_bytes();
      test_length_bounds();
      test_random_traffic(12, 66, 1'b0, 17'd5, 24'd64, 50);
      test_random_traffic(66, 12, 1'b1, 17'd12, 24'd300, 50);
      test_random_traffic(0, 0, 1'b0, 17'd0, 24'd2000, 50);
      if (mismatches == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
